// ===== rtl/gpl_pkg.sv =====
// Shared types, codes and helpers for the GPIO port with configuration lock.
`timescale 1ns / 1ps

package gpl_pkg;

	// Port geometry and reset values
	localparam int PIN_W = 16;
	localparam int PIN_COUNT_DEF = 16;
	localparam int DATA_W = 32;
	localparam int KEY_BIT = 16;
	localparam logic [DATA_W-1:0] CONFIG_RESET = 32'h4444_4444;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		SEL_CRL    = 3'd0,
		SEL_CRH    = 3'd1,
		SEL_IDR    = 3'd2,
		SEL_ODR    = 3'd3,
		SEL_BSRR   = 3'd4,
		SEL_BRR    = 3'd5,
		SEL_LCKR   = 3'd6,
		SEL_UNUSED = 3'd7
	} sel_t;

	typedef enum logic [1:0] {
		LK_IDLE  = 2'd0,
		LK_ONE   = 2'd1,
		LK_TWO   = 2'd2,
		LK_THREE = 2'd3
	} lock_stage_t;

	// LCKR access for the beat that advances this cycle
	typedef struct packed {
		logic             wr;
		logic             rd;
		logic             key;
		logic [PIN_W-1:0] bits;
	} lock_acc_t;

	// Lock register contents
	typedef struct packed {
		logic             key;
		logic [PIN_W-1:0] mask;
	} lock_sts_t;

	// Replace the writable mode nibbles of a configuration word
	function automatic logic [DATA_W-1:0] merge_config(
		input logic [DATA_W-1:0] old_word,
		input logic [DATA_W-1:0] new_word,
		input logic [7:0]        writable
	);
		logic [DATA_W-1:0] result;
		result = old_word;
		for (int i = 0; i < 8; i++) begin
			if (writable[i]) begin
				result[4*i +: 4] = new_word[4*i +: 4];
			end
		end
		return result;
	endfunction

endpackage

// ===== rtl/gpl_lock.sv =====
// Lock key sequencer with the lock mask and key registers.
`timescale 1ns / 1ps

module gpl_lock (
	input  logic                clk,
	input  logic                arst_n,
	input  gpl_pkg::lock_acc_t  acc,
	output gpl_pkg::lock_sts_t  sts
);

	gpl_pkg::lock_stage_t            stage_q, stage_d;
	logic [gpl_pkg::PIN_W-1:0]       mask_q, mask_d;
	logic                            key_q, key_d;
	logic                            same;

	// Register stage, mask and key; reset clears all three
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= gpl_pkg::LK_IDLE;
			mask_q  <= '0;
			key_q   <= 1'b0;
		end else begin
			stage_q <= stage_d;
			mask_q  <= mask_d;
			key_q   <= key_d;
		end
	end

	assign same = (acc.bits == mask_q);

	// Unlocked writes step, restart or idle the key sequence; a read idles it, setting the key in stage three
	always_comb begin
		stage_d = stage_q;
		mask_d  = mask_q;
		key_d   = key_q;
		if (acc.wr) begin
			if (!key_q) begin
				mask_d = acc.bits;
				priority if (stage_q == gpl_pkg::LK_ONE && !acc.key && same) begin
					stage_d = gpl_pkg::LK_TWO;
				end else if (stage_q == gpl_pkg::LK_TWO && acc.key && same) begin
					stage_d = gpl_pkg::LK_THREE;
				end else if (acc.key) begin
					stage_d = gpl_pkg::LK_ONE;
				end else begin
					stage_d = gpl_pkg::LK_IDLE;
				end
			end
		end else if (acc.rd) begin
			if (stage_q == gpl_pkg::LK_THREE) begin
				key_d = 1'b1;
			end
			stage_d = gpl_pkg::LK_IDLE;
		end
	end

	assign sts.key  = key_q;
	assign sts.mask = mask_q;

endmodule

// ===== rtl/gpl_port.sv =====
// Port register file: mode words, output latch, read mux and lock control.
`timescale 1ns / 1ps

module gpl_port #(
	parameter int PIN_COUNT = gpl_pkg::PIN_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  gpl_pkg::cmd_t                 cmd,
	input  gpl_pkg::sel_t                 sel,
	input  logic [gpl_pkg::DATA_W-1:0]    data,
	input  logic [gpl_pkg::PIN_W-1:0]     pads,
	output logic [gpl_pkg::DATA_W-1:0]    rd_data,
	output logic [gpl_pkg::PIN_W-1:0]     latch,
	output logic [gpl_pkg::DATA_W-1:0]    crl,
	output logic [gpl_pkg::DATA_W-1:0]    crh,
	output logic                          key
);

	// Pins that exist on this port
	localparam logic [gpl_pkg::DATA_W-1:0] PinMaskW = (32'd1 << PIN_COUNT) - 32'd1;
	localparam logic [gpl_pkg::PIN_W-1:0]  PinMask  = PinMaskW[gpl_pkg::PIN_W-1:0];

	logic [gpl_pkg::DATA_W-1:0] crl_q, crl_d, crh_q, crh_d;
	logic [gpl_pkg::PIN_W-1:0]  latch_q, latch_d;
	logic [gpl_pkg::PIN_W-1:0]  data_lo, data_hi;
	logic [7:0]                 lo_wr, hi_wr;
	logic                       wr_beat, rd_beat;
	gpl_pkg::lock_acc_t         lock_acc;
	gpl_pkg::lock_sts_t         lock_sts;

	assign wr_beat = adv && (cmd == gpl_pkg::CMD_WRITE);
	assign rd_beat = adv && (cmd == gpl_pkg::CMD_READ);
	assign data_lo = data[gpl_pkg::PIN_W-1:0];
	assign data_hi = data[gpl_pkg::DATA_W-1:gpl_pkg::PIN_W];

	// Steer LCKR beats to the sequencer
	assign lock_acc.wr   = wr_beat && (sel == gpl_pkg::SEL_LCKR);
	assign lock_acc.rd   = rd_beat && (sel == gpl_pkg::SEL_LCKR);
	assign lock_acc.key  = data[gpl_pkg::KEY_BIT];
	assign lock_acc.bits = data_lo & PinMask;

	gpl_lock u_lock (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (lock_acc),
		.sts    (lock_sts)
	);

	// Nibbles open to writes: present pins that are not locked
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			lo_wr[i] = PinMask[i] && !(lock_sts.key && lock_sts.mask[i]);
			hi_wr[i] = PinMask[i+8] && !(lock_sts.key && lock_sts.mask[i+8]);
		end
	end

	// Compute register updates for a write beat
	always_comb begin
		crl_d   = crl_q;
		crh_d   = crh_q;
		latch_d = latch_q;
		if (wr_beat) begin
			unique case (sel)
				gpl_pkg::SEL_CRL:  crl_d = gpl_pkg::merge_config(crl_q, data, lo_wr);
				gpl_pkg::SEL_CRH:  crh_d = gpl_pkg::merge_config(crh_q, data, hi_wr);
				gpl_pkg::SEL_ODR:  latch_d = data_lo & PinMask;
				gpl_pkg::SEL_BSRR: latch_d = ((latch_q & ~data_hi) | data_lo) & PinMask;
				gpl_pkg::SEL_BRR:  latch_d = latch_q & ~data_lo & PinMask;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crl_q   <= gpl_pkg::CONFIG_RESET;
			crh_q   <= gpl_pkg::CONFIG_RESET;
			latch_q <= '0;
		end else begin
			crl_q   <= crl_d;
			crh_q   <= crh_d;
			latch_q <= latch_d;
		end
	end

	// Select the read value from the state before this beat
	always_comb begin
		rd_data = '0;
		if (cmd == gpl_pkg::CMD_READ) begin
			unique case (sel)
				gpl_pkg::SEL_CRL:    rd_data = crl_q;
				gpl_pkg::SEL_CRH:    rd_data = crh_q;
				gpl_pkg::SEL_IDR:    rd_data = {16'd0, pads & PinMask};
				gpl_pkg::SEL_ODR:    rd_data = {16'd0, latch_q};
				gpl_pkg::SEL_LCKR:   rd_data = {15'd0, lock_sts.key, lock_sts.mask};
				gpl_pkg::SEL_BSRR,
				gpl_pkg::SEL_BRR,
				gpl_pkg::SEL_UNUSED: rd_data = '0;
			endcase
		end
	end

	assign latch = latch_q;
	assign crl   = crl_q;
	assign crh   = crh_q;
	assign key   = lock_sts.key;

endmodule

// ===== rtl/gpio_port_with_config_lock.sv =====
// An accepted beat is held until it advances; the register file then updates once and
// the result is registered. One access per cycle unless a stalled response holds it.
// The response register parts the channels; a request stalls only while a response waits.
// Reset (arst_n low, asynchronous): mode words 0x44444444, latch, lock mask, key and
// sequencer cleared; both valid flags cleared.
`timescale 1ns / 1ps

module gpio_port_with_config_lock #(
	parameter int PIN_COUNT = gpl_pkg::PIN_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       command,
	input  logic [2:0]                 register_select,
	input  logic [gpl_pkg::DATA_W-1:0] write_data,
	input  logic [gpl_pkg::PIN_W-1:0]  pin_levels,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [gpl_pkg::DATA_W-1:0] read_data,
	output logic [gpl_pkg::PIN_W-1:0]  pin_drive,
	output logic [gpl_pkg::DATA_W-1:0] mode_low_pins,
	output logic [gpl_pkg::DATA_W-1:0] mode_high_pins,
	output logic                       lock_active
);

	logic                       valid_s1;
	gpl_pkg::cmd_t              cmd_s1;
	gpl_pkg::sel_t              sel_s1;
	logic [gpl_pkg::DATA_W-1:0] data_s1;
	logic [gpl_pkg::PIN_W-1:0]  pads_s1;
	logic                       rsp_valid_q;
	logic [gpl_pkg::DATA_W-1:0] read_data_q;
	logic [gpl_pkg::DATA_W-1:0] rd_value;
	logic                       accept, adv;

	// Advance the held beat when the response slot is free or being taken
	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the request beat
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= gpl_pkg::cmd_t'(command);
			sel_s1  <= gpl_pkg::sel_t'(register_select);
			data_s1 <= write_data;
			pads_s1 <= pin_levels;
		end
	end

	gpl_port #(
		.PIN_COUNT (PIN_COUNT)
	) u_port (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.cmd     (cmd_s1),
		.sel     (sel_s1),
		.data    (data_s1),
		.pads    (pads_s1),
		.rd_data (rd_value),
		.latch   (pin_drive),
		.crl     (mode_low_pins),
		.crh     (mode_high_pins),
		.key     (lock_active)
	);

	// Hold the read value with its beat
	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q <= rd_value;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;

endmodule

// ===== rtl/gpl_checker.sv =====
// Port-level checks for the GPIO port, bound to the top level.
`timescale 1ns / 1ps

module gpl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] read_data,
	input logic [15:0] pin_drive,
	input logic        lock_active
);

	// A waiting response beat stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	// A stalled response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(read_data) && $stable(pin_drive))
		else $error("response payload changed while stalled");

	// Requests stall only behind a stalled response
	a_req_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled with a free response slot");

	// The lock key is cleared only by reset
	a_key_held: assert property (@(posedge clk) disable iff (!arst_n)
		lock_active |=> lock_active)
		else $error("lock key cleared outside reset");

	// The lock key sets only with a delivered beat
	a_key_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(lock_active) |-> rsp_valid)
		else $error("lock key set outside the key sequence");

endmodule

bind gpio_port_with_config_lock gpl_checker u_gpl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.read_data   (read_data),
	.pin_drive   (pin_drive),
	.lock_active (lock_active)
);
